// File: design/assert_macros.svh
// assertion macros for the contrast stretch block
// used by every module that checks its own logic; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HPCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define HPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/hpcs_pkg.sv
// shared types, codes and constants of the contrast stretch block
// no dependencies
package hpcs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int PIXEL_BITS     = 16;
    localparam int CLIP_BITS      = 14;
    localparam int OUT_BITS       = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SCALE_BITS     = 14;

    localparam logic [SCALE_BITS-1:0] SCALE_FULL = 14'd10000;

    localparam logic [1:0] OP_HIST    = 2'd0;
    localparam logic [1:0] OP_RANGE   = 2'd1;
    localparam logic [1:0] OP_STRETCH = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_CLIP  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_CLIP = 2'd1;

    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic [1:0]            op;
        logic [PIXEL_BITS-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [OUT_BITS-1:0]   pixel_out;
        logic [PIXEL_BITS-1:0] range_low;
        logic [PIXEL_BITS-1:0] range_high;
    } out_item_t;

    typedef struct packed {
        logic                  start;
        logic [PIXEL_BITS-1:0] diff;
        logic [PIXEL_BITS-1:0] span;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST_WR,
        ST_GOAL,
        ST_CHK,
        ST_MUL,
        ST_ADD,
        ST_STR,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// File: design/hpcs_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module hpcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/hpcs_div.sv
// restoring divider for the stretch: one quotient bit per cycle
// depends on hpcs_pkg and assert_macros.svh
`include "assert_macros.svh"
module hpcs_div #(
    parameter int SAMPLE_BITS = hpcs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hpcs_pkg::div_req_t            req,
    output logic                          done,
    output logic [hpcs_pkg::OUT_BITS-1:0] quo
);

    localparam int QB = hpcs_pkg::OUT_BITS;
    localparam int CW = $clog2(QB);
    localparam logic [CW-1:0] LAST = CW'(QB - 1);

    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] span_reg, span_next;
    logic [QB-1:0]          quo_reg, quo_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SAMPLE_BITS:0]   r2;
    logic                   ge;

    // one restoring step
    always_comb
    begin
        r2        = {rem_reg, 1'b0};
        ge        = r2 >= {1'b0, span_reg};
        rem_next  = rem_reg;
        span_next = span_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.diff[SAMPLE_BITS-1:0];
            span_next = req.span[SAMPLE_BITS-1:0];
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? SAMPLE_BITS'(r2 - {1'b0, span_reg}) : SAMPLE_BITS'(r2);
            quo_next = {quo_reg[QB-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        span_reg <= span_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    `HPCS_ASSERT_SAME(a_start_idle, clk, rst_n, req.start, !busy_reg)
    `HPCS_ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `HPCS_ASSERT_NEXT(a_last_done, clk, rst_n, busy_reg && cnt_reg == LAST, done_reg)

endmodule

// File: design/histogram_percentile_contrast_stretch.sv
// top level of the percentile clipped contrast stretch, 16 to 8 bit
// depends on hpcs_pkg, hpcs_ram, hpcs_div and assert_macros.svh
//
// channel  | valid        | stall        | beat
// sample   | sample_valid | sample_stall | sample (op, pixel)
// result   | result_valid | result_stall | result (kind, pixel, bounds)
// cfg      | cfg_we       | none         | cfg_index, cfg_data
//
// histogram beat: bin read, then saturating write back
// stretch beat: compare then output, with the 8 step divider between them for pixels inside the range
// range beat: goals, then check, multiply and add for each bin walked, from both ends
// clear beat and the pass after reset: zero one bin a cycle
// a stalled result holds the next result in its state; no beat is taken meanwhile
`include "assert_macros.svh"
module histogram_percentile_contrast_stretch #(
    parameter int SAMPLE_BITS = hpcs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = hpcs_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  hpcs_pkg::in_item_t                  sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output hpcs_pkg::out_item_t                 result,
    input  logic                                cfg_we,
    input  logic [hpcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hpcs_pkg::CLIP_BITS-1:0]      cfg_data
);

    localparam int PB  = hpcs_pkg::PIXEL_BITS;
    localparam int OB  = hpcs_pkg::OUT_BITS;
    localparam int CB  = hpcs_pkg::CLIP_BITS;
    localparam int GB  = COUNT_BITS + CB;
    localparam int AB  = COUNT_BITS + 16;
    localparam int DEPTH = 1 << SAMPLE_BITS;
    localparam logic [SAMPLE_BITS-1:0] BIN_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [OB-1:0] OUT_MAX = {OB{1'b1}};

    hpcs_pkg::state_t state_reg, state_next;

    logic [CB-1:0]          low_clip_reg, low_clip_next;
    logic [CB-1:0]          high_clip_reg, high_clip_next;
    logic [COUNT_BITS-1:0]  total_reg, total_next;
    logic [SAMPLE_BITS-1:0] range_low_reg, range_low_next;
    logic [SAMPLE_BITS-1:0] range_high_reg, range_high_next;
    logic [SAMPLE_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [SAMPLE_BITS-1:0] addr_reg, addr_next;
    logic [SAMPLE_BITS-1:0] lo_found_reg, lo_found_next;
    logic                   dir_reg, dir_next;
    logic                   end_reg, end_next;
    logic [GB-1:0]          goal_lo_reg, goal_lo_next;
    logic [GB-1:0]          goal_hi_reg, goal_hi_next;
    logic [AB-1:0]          acc_reg, acc_next;
    logic [AB-1:0]          mul_reg, mul_next;
    hpcs_pkg::out_item_t    res_reg, res_next;
    hpcs_pkg::out_item_t    result_reg, result_next;
    logic                   result_valid_reg, result_valid_next;

    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] ram_waddr;
    logic [COUNT_BITS-1:0]  ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_raddr;
    logic [COUNT_BITS-1:0]  ram_rdata;

    hpcs_pkg::div_req_t     div_req;
    logic                   div_done;
    logic [OB-1:0]          div_quo;

    logic                   accept;
    logic                   out_free;
    logic [GB-1:0]          goal;
    logic [AB:0]            need;
    logic [SAMPLE_BITS-1:0] span;
    logic [SAMPLE_BITS-1:0] diff;

    hpcs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hpcs_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign sample_stall = (state_reg != hpcs_pkg::ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // walk compare, span and offset for the stretch
    always_comb
    begin
        goal = dir_reg ? goal_hi_reg : goal_lo_reg;
        need = {1'b0, acc_reg} + (AB + 1)'(hpcs_pkg::SCALE_FULL);
        span = (range_high_reg > range_low_reg) ? (range_high_reg - range_low_reg)
                                                : SAMPLE_BITS'(1);
        diff = addr_reg - range_low_reg;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        low_clip_next     = low_clip_reg;
        high_clip_next    = high_clip_reg;
        total_next        = total_reg;
        range_low_next    = range_low_reg;
        range_high_next   = range_high_reg;
        clr_addr_next     = clr_addr_reg;
        addr_next         = addr_reg;
        lo_found_next     = lo_found_reg;
        dir_next          = dir_reg;
        end_next          = end_reg;
        goal_lo_next      = goal_lo_reg;
        goal_hi_next      = goal_hi_reg;
        acc_next          = acc_reg;
        mul_next          = mul_reg;
        res_next          = res_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        ram_we            = 1'b0;
        ram_waddr         = addr_reg;
        ram_wdata         = '0;
        ram_raddr         = sample.pixel[SAMPLE_BITS-1:0];
        div_req.start     = 1'b0;
        div_req.diff      = PB'(diff);
        div_req.span      = PB'(span);

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                hpcs_pkg::CFG_LOW_CLIP:  low_clip_next  = cfg_data;
                hpcs_pkg::CFG_HIGH_CLIP: high_clip_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            // zero one bin a cycle
            hpcs_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                total_next    = '0;
                if (clr_addr_reg == BIN_MAX)
                begin
                    state_next = hpcs_pkg::ST_IDLE;
                end
            end
            hpcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = sample.pixel[SAMPLE_BITS-1:0];
                    case (sample.op)
                        hpcs_pkg::OP_HIST:    state_next = hpcs_pkg::ST_HIST_WR;
                        hpcs_pkg::OP_RANGE:   state_next = hpcs_pkg::ST_GOAL;
                        hpcs_pkg::OP_STRETCH: state_next = hpcs_pkg::ST_STR;
                        hpcs_pkg::OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = hpcs_pkg::ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            // saturating bin and total update
            hpcs_pkg::ST_HIST_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
                total_next = (&total_reg) ? total_reg : total_reg + 1'b1;
                state_next = hpcs_pkg::ST_IDLE;
            end
            // scaled clip goals: clip * total, compared against acc plus 10000, acc summing bin * 10000
            hpcs_pkg::ST_GOAL:
            begin
                goal_lo_next = GB'(low_clip_reg * total_reg);
                goal_hi_next = GB'(high_clip_reg * total_reg);
                acc_next     = '0;
                addr_next    = '0;
                dir_next     = 1'b0;
                end_next     = 1'b0;
                state_next   = hpcs_pkg::ST_CHK;
            end
            hpcs_pkg::ST_CHK:
            begin
                ram_raddr = addr_reg;
                if (!end_reg && need <= (AB + 1)'(goal))
                begin
                    state_next = hpcs_pkg::ST_MUL;
                end
                else if (!dir_reg)
                begin
                    lo_found_next = addr_reg;
                    dir_next      = 1'b1;
                    end_next      = 1'b0;
                    acc_next      = '0;
                    addr_next     = BIN_MAX;
                end
                else
                begin
                    range_low_next       = lo_found_reg;
                    range_high_next      = addr_reg;
                    res_next.result_kind = hpcs_pkg::KIND_RANGE;
                    res_next.pixel_out   = '0;
                    res_next.range_low   = PB'(lo_found_reg);
                    res_next.range_high  = PB'(addr_reg);
                    state_next           = hpcs_pkg::ST_OUT;
                end
            end
            hpcs_pkg::ST_MUL:
            begin
                mul_next   = AB'(ram_rdata * hpcs_pkg::SCALE_FULL);
                state_next = hpcs_pkg::ST_ADD;
            end
            // accumulate and step, stopping at the histogram ends
            hpcs_pkg::ST_ADD:
            begin
                acc_next   = acc_reg + mul_reg;
                state_next = hpcs_pkg::ST_CHK;
                if (!dir_reg)
                begin
                    if (addr_reg == BIN_MAX)
                        end_next = 1'b1;
                    else
                        addr_next = addr_reg + 1'b1;
                end
                else
                begin
                    if (addr_reg == '0)
                        end_next = 1'b1;
                    else
                        addr_next = addr_reg - 1'b1;
                end
            end
            hpcs_pkg::ST_STR:
            begin
                res_next.result_kind = hpcs_pkg::KIND_PIXEL;
                res_next.range_low   = PB'(range_low_reg);
                res_next.range_high  = PB'(range_high_reg);
                if (addr_reg < range_low_reg)
                begin
                    res_next.pixel_out = '0;
                    state_next         = hpcs_pkg::ST_OUT;
                end
                else if (diff >= span)
                begin
                    res_next.pixel_out = OUT_MAX;
                    state_next         = hpcs_pkg::ST_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = hpcs_pkg::ST_DIV;
                end
            end
            hpcs_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_next.pixel_out = div_quo;
                    state_next         = hpcs_pkg::ST_OUT;
                end
            end
            // hand over to the output register once it is free
            hpcs_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                    state_next        = hpcs_pkg::ST_IDLE;
                end
            end
            default: state_next = hpcs_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hpcs_pkg::ST_CLEAR;
            low_clip_reg     <= '0;
            high_clip_reg    <= '0;
            total_reg        <= '0;
            range_low_reg    <= '0;
            range_high_reg   <= BIN_MAX;
            clr_addr_reg     <= '0;
            dir_reg          <= 1'b0;
            end_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            low_clip_reg     <= low_clip_next;
            high_clip_reg    <= high_clip_next;
            total_reg        <= total_next;
            range_low_reg    <= range_low_next;
            range_high_reg   <= range_high_next;
            clr_addr_reg     <= clr_addr_next;
            dir_reg          <= dir_next;
            end_reg          <= end_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        lo_found_reg <= lo_found_next;
        goal_lo_reg  <= goal_lo_next;
        goal_hi_reg  <= goal_hi_next;
        acc_reg      <= acc_next;
        mul_reg      <= mul_next;
        res_reg      <= res_next;
        result_reg   <= result_next;
    end

    `HPCS_ASSERT_NEXT(a_clear_total, clk, rst_n,
        state_reg == hpcs_pkg::ST_CLEAR && clr_addr_reg == BIN_MAX, total_reg == '0)
    `HPCS_ASSERT_SAME(a_div_wait, clk, rst_n, div_done, state_reg == hpcs_pkg::ST_DIV)
    `HPCS_ASSERT_SAME(a_bin_write, clk, rst_n, ram_we,
        state_reg == hpcs_pkg::ST_CLEAR || state_reg == hpcs_pkg::ST_HIST_WR)

endmodule

// File: dv/tb_histogram_percentile_contrast_stretch.sv
// self-checking testbench of the percentile clipped contrast stretch block
// depends on hpcs_pkg and histogram_percentile_contrast_stretch
`timescale 1ns / 1ps
module tb_histogram_percentile_contrast_stretch;

    localparam logic [hpcs_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd2;
    localparam int unsigned BIN_TOP   = 65535;
    localparam longint unsigned COUNT_TOP = 64'hFFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 2000000;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    hpcs_pkg::in_item_t sample;
    logic result_valid;
    logic result_stall;
    hpcs_pkg::out_item_t result;
    logic cfg_we;
    logic [hpcs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [hpcs_pkg::CLIP_BITS-1:0] cfg_data;

    // stimulus waiting to be driven and results still owed by the block
    hpcs_pkg::in_item_t pending_samples[$];
    hpcs_pkg::out_item_t owed_results[$];

    // shadow of the block state
    longint unsigned bin_count[int unsigned];
    longint unsigned pixel_count;
    int unsigned bound_low;
    int unsigned bound_high;
    int unsigned clip_low;
    int unsigned clip_high;

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int beats_in;
    int beats_out;
    int range_reports;
    int quiet_cycles;

    histogram_percentile_contrast_stretch i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // clip walk from both ends of the histogram
    function automatic void walk_bounds();
        longint unsigned goal_lo;
        longint unsigned goal_hi;
        longint unsigned acc;
        int unsigned lo;
        int unsigned hi;
        goal_lo = (longint'(clip_low) * pixel_count) / 10000;
        goal_hi = (longint'(clip_high) * pixel_count) / 10000;
        acc = 0;
        lo = 0;
        while (acc < goal_lo)
        begin
            if (bin_count.exists(lo))
                acc += bin_count[lo];
            if (lo < BIN_TOP)
                lo++;
            else
                break;
        end
        acc = 0;
        hi = BIN_TOP;
        while (acc < goal_hi)
        begin
            if (bin_count.exists(hi))
                acc += bin_count[hi];
            if (hi > 0)
                hi--;
            else
                break;
        end
        bound_low = lo;
        bound_high = hi;
    endfunction

    function automatic logic [hpcs_pkg::OUT_BITS-1:0] stretch_pixel(int unsigned p);
        int unsigned span;
        int unsigned v;
        if (p < bound_low)
            return '0;
        span = (bound_high > bound_low) ? bound_high - bound_low : 1;
        v = ((p - bound_low) * 256) / span;
        return (v > 255) ? 8'd255 : v[hpcs_pkg::OUT_BITS-1:0];
    endfunction

    // update the shadow state for one accepted beat, queue what it owes
    function automatic void predict_beat(hpcs_pkg::in_item_t s);
        hpcs_pkg::out_item_t r;
        int unsigned p;
        p = s.pixel;
        r = '0;
        case (s.op)
            hpcs_pkg::OP_HIST:
            begin
                if (!bin_count.exists(p))
                    bin_count[p] = 0;
                if (bin_count[p] < COUNT_TOP)
                    bin_count[p]++;
                if (pixel_count < COUNT_TOP)
                    pixel_count++;
            end
            hpcs_pkg::OP_RANGE:
            begin
                walk_bounds();
                r.result_kind = hpcs_pkg::KIND_RANGE;
                r.range_low = bound_low[hpcs_pkg::PIXEL_BITS-1:0];
                r.range_high = bound_high[hpcs_pkg::PIXEL_BITS-1:0];
                owed_results.push_back(r);
            end
            hpcs_pkg::OP_STRETCH:
            begin
                r.result_kind = hpcs_pkg::KIND_PIXEL;
                r.pixel_out = stretch_pixel(p);
                r.range_low = bound_low[hpcs_pkg::PIXEL_BITS-1:0];
                r.range_high = bound_high[hpcs_pkg::PIXEL_BITS-1:0];
                owed_results.push_back(r);
            end
            default:
            begin
                bin_count.delete();
                pixel_count = 0;
            end
        endcase
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        logic taken;
        logic next_valid;
        hpcs_pkg::in_item_t next_sample;
        taken = rst_n && sample_valid && !sample_stall;
        next_valid = sample_valid;
        next_sample = sample;
        if (taken)
        begin
            predict_beat(sample);
            beats_in++;
        end
        if (!sample_valid || taken)
        begin
            next_valid = 1'b0;
            if (rst_n && pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_sample = pending_samples.pop_front();
                next_valid = 1'b1;
            end
        end
        sample_valid <= next_valid;
        sample <= next_sample;
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin
        hpcs_pkg::out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            beats_out++;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, result);
                errors++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (want.result_kind == hpcs_pkg::KIND_RANGE)
                    range_reports++;
                if (result.result_kind !== want.result_kind)
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             want.result_kind, result.result_kind);
                if (result.pixel_out !== want.pixel_out)
                    $display("%0t: pixel_out expected %0d actual %0d", $time,
                             want.pixel_out, result.pixel_out);
                if (result.range_low !== want.range_low)
                    $display("%0t: range_low expected %0d actual %0d", $time,
                             want.range_low, result.range_low);
                if (result.range_high !== want.range_high)
                    $display("%0t: range_high expected %0d actual %0d", $time,
                             want.range_high, result.range_high);
                if (result !== want)
                    errors++;
            end
        end
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // watchdog on beats in either direction
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("histogram_percentile_contrast_stretch test failed");
            $finish;
        end
    end

    task automatic push_beat(logic [1:0] op, int unsigned p);
        hpcs_pkg::in_item_t s;
        s.op = op;
        s.pixel = p[hpcs_pkg::PIXEL_BITS-1:0];
        pending_samples.push_back(s);
    endtask

    task automatic write_reg(logic [hpcs_pkg::CFG_INDEX_BITS-1:0] idx, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[hpcs_pkg::CLIP_BITS-1:0];
        if (idx == hpcs_pkg::CFG_LOW_CLIP)
            clip_low = value;
        else if (idx == hpcs_pkg::CFG_HIGH_CLIP)
            clip_high = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle(idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 23 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 64 : (mode == IDLE_BOTH) ? 23 : 0;
    endtask

    // every phase ends on a beat that owes a result, so this means idle
    task automatic drain();
        while (pending_samples.size() > 0 || sample_valid || owed_results.size() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // histogram pixels sit near the ends so the clip walks stay short
    function automatic int unsigned image_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return $urandom_range(0, BIN_TOP);
        else if (pick < 52)
            return $urandom_range(0, 255);
        else
            return BIN_TOP - $urandom_range(0, 255);
    endfunction

    task automatic build_image(bit with_clear);
        int n;
        int unsigned pick;
        if (with_clear)
            push_beat(hpcs_pkg::OP_CLEAR, $urandom_range(0, BIN_TOP));
        n = $urandom_range(40, 90);
        repeat (n)
            push_beat(hpcs_pkg::OP_HIST, image_pixel());
        push_beat(hpcs_pkg::OP_RANGE, $urandom_range(0, BIN_TOP));
        n = $urandom_range(30, 60);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            // mostly stretch beats, some stray histogram and range beats
            if (pick < 85)
                push_beat(hpcs_pkg::OP_STRETCH, $urandom_range(0, BIN_TOP));
            else if (pick < 95)
                push_beat(hpcs_pkg::OP_HIST, image_pixel());
            else
                push_beat(hpcs_pkg::OP_RANGE, $urandom_range(0, BIN_TOP));
        end
        push_beat(hpcs_pkg::OP_STRETCH, $urandom_range(0, BIN_TOP));
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_count = 0;
        bound_low = 0;
        bound_high = BIN_TOP;
        clip_low = 0;
        clip_high = 0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        range_reports = 0;
        quiet_cycles = 0;
        set_idle(IDLE_NONE);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset bounds, extreme pixels, zero clip
        push_beat(hpcs_pkg::OP_STRETCH, 0);
        push_beat(hpcs_pkg::OP_STRETCH, BIN_TOP);
        push_beat(hpcs_pkg::OP_STRETCH, 16'h5555);
        push_beat(hpcs_pkg::OP_HIST, 0);
        push_beat(hpcs_pkg::OP_HIST, BIN_TOP);
        push_beat(hpcs_pkg::OP_HIST, 0);
        push_beat(hpcs_pkg::OP_HIST, 16'hAAAA);
        push_beat(hpcs_pkg::OP_RANGE, 0);
        push_beat(hpcs_pkg::OP_STRETCH, 16'h8000);
        drain();

        // clips at and above full scale: both walks run to the histogram ends
        write_reg(hpcs_pkg::CFG_LOW_CLIP, 10000);
        write_reg(hpcs_pkg::CFG_HIGH_CLIP, 16383);
        write_reg(CFG_SPARE, 123);
        push_beat(hpcs_pkg::OP_RANGE, BIN_TOP);
        // inverted range, divisor forced to one
        push_beat(hpcs_pkg::OP_STRETCH, 0);
        push_beat(hpcs_pkg::OP_STRETCH, BIN_TOP - 1);
        push_beat(hpcs_pkg::OP_STRETCH, BIN_TOP);
        drain();

        // clear then range over an empty histogram
        write_reg(hpcs_pkg::CFG_LOW_CLIP, 5000);
        write_reg(hpcs_pkg::CFG_HIGH_CLIP, 5000);
        push_beat(hpcs_pkg::OP_CLEAR, 16'hFFFF);
        push_beat(hpcs_pkg::OP_RANGE, 16'h1234);
        push_beat(hpcs_pkg::OP_HIST, 100);
        push_beat(hpcs_pkg::OP_HIST, 100);
        push_beat(hpcs_pkg::OP_HIST, 101);
        push_beat(hpcs_pkg::OP_HIST, 101);
        push_beat(hpcs_pkg::OP_RANGE, 0);
        push_beat(hpcs_pkg::OP_STRETCH, 100);
        push_beat(hpcs_pkg::OP_STRETCH, 101);
        push_beat(hpcs_pkg::OP_STRETCH, 99);
        drain();

        // random images under changing clips and idle patterns
        for (int ph = 0; ph < 14; ph++)
        begin
            set_idle(idle_mode_t'(ph % 4));
            case (ph % 5)
                0:
                begin
                    write_reg(hpcs_pkg::CFG_LOW_CLIP, 0);
                    write_reg(hpcs_pkg::CFG_HIGH_CLIP, 4000);
                end
                1:
                begin
                    write_reg(hpcs_pkg::CFG_LOW_CLIP, 4000);
                    write_reg(hpcs_pkg::CFG_HIGH_CLIP, 0);
                end
                default:
                begin
                    write_reg(hpcs_pkg::CFG_LOW_CLIP, $urandom_range(0, 4000));
                    write_reg(hpcs_pkg::CFG_HIGH_CLIP, $urandom_range(0, 4000));
                end
            endcase
            build_image(ph % 5 == 2);
            drain();
        end

        $display("%0d sample beats and %0d result beats checked, %0d range reports",
                 beats_in, beats_out, range_reports);
        $display("covered clip extremes, inverted range, clears and four idle patterns");
        if (errors == 0)
            $display("histogram_percentile_contrast_stretch test passed");
        else
            $display("histogram_percentile_contrast_stretch test failed");
        $finish;
    end

endmodule
